// ----- hdl/tmpsl_pkg.sv -----
// ----------------------------------------------------------------------------
// tmpsl_pkg - shared types and constants of the three-motor PID speed loop
// Widths, gain format, register codes and the records that lanes, the
// result queue and the top level exchange.
// ----------------------------------------------------------------------------
package tmpsl_pkg;

    localparam int GAIN_FRAC_BITS = 12;
    localparam int MOTOR_COUNT    = 3;
    localparam int DATA_W         = 16;

    // unsigned 16-bit gain (as 17-bit signed) times signed 16-bit operand
    localparam int PROD_W = 2 * DATA_W + 1;
    // sum of three products
    localparam int ACC_W  = PROD_W + 2;
    // magnitude after the fixed-point shift
    localparam int MAG_W  = ACC_W - GAIN_FRAC_BITS;

    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CREDIT_W    = QUEUE_IDX_W + 1;

    localparam int REG_IDX_W = 2;
    localparam int PADDR_W   = REG_IDX_W + 2;
    localparam int PDATA_W   = 32;

    localparam logic [DATA_W-1:0] KP_RESET = DATA_W'(1229);
    localparam logic [DATA_W-1:0] KD_RESET = DATA_W'(41);
    localparam logic [DATA_W-1:0] KI_RESET = DATA_W'(41);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_KP = 2'd0,
        REG_KD = 2'd1,
        REG_KI = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] kp;
        logic [DATA_W-1:0] kd;
        logic [DATA_W-1:0] ki;
    } gains_t;

    typedef struct packed {
        logic                     forward;
        logic [DATA_W-1:0]        drive;
        logic signed [DATA_W-1:0] speed;
    } lane_res_t;

    typedef lane_res_t [MOTOR_COUNT-1:0] beat_t;

endpackage

// ----- hdl/three_motor_pid_speed_loop_top.sv -----
// ----------------------------------------------------------------------------
// three_motor_pid_speed_loop_top - PID speed loop for three motors
// Three lanes compute speed, error and drive per control tick; a queue
// merges their results into one output beat.
// ----------------------------------------------------------------------------
// One input beat is one control tick carrying an encoder count and a speed
// setpoint per motor. Each motor's lane takes the 16-bit wrapped count
// change as measured speed, forms error = setpoint - speed, adds it into a
// wrapping 16-bit error sum, and drives kp*error + kd*speed + ki*sum with
// unsigned Q4.12 gains, truncated toward zero and saturated to signed 16
// bits. The output beat gives per motor a forward bit, the drive magnitude
// (0..32768) and the speed. A new tick is accepted every cycle while in_ready
// is high; the result passes through a register stage for the error path,
// one for the three gain multipliers of each lane and one for their sum,
// then waits in an eight-beat result queue. in_ready drops only when eight
// ticks are accepted and not yet delivered. Gains sit on an APB port at
// byte addresses 0 (kp), 4 (kd) and 8 (ki), reset to 1229, 41 and 41; write
// them only while no tick is in flight. Reset clears the previous counts
// and the error sums.
// ----------------------------------------------------------------------------
module three_motor_pid_speed_loop_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // tick channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [tmpsl_pkg::DATA_W-1:0]  position_a,
    input  logic signed [tmpsl_pkg::DATA_W-1:0]  position_b,
    input  logic signed [tmpsl_pkg::DATA_W-1:0]  position_c,
    input  logic signed [tmpsl_pkg::DATA_W-1:0]  setpoint_a,
    input  logic signed [tmpsl_pkg::DATA_W-1:0]  setpoint_b,
    input  logic signed [tmpsl_pkg::DATA_W-1:0]  setpoint_c,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 forward_a,
    output logic [tmpsl_pkg::DATA_W-1:0]         drive_a,
    output logic signed [tmpsl_pkg::DATA_W-1:0]  speed_a,
    output logic                                 forward_b,
    output logic [tmpsl_pkg::DATA_W-1:0]         drive_b,
    output logic signed [tmpsl_pkg::DATA_W-1:0]  speed_b,
    output logic                                 forward_c,
    output logic [tmpsl_pkg::DATA_W-1:0]         drive_c,
    output logic signed [tmpsl_pkg::DATA_W-1:0]  speed_c,
    // APB configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tmpsl_pkg::PADDR_W-1:0]        paddr,
    input  logic [tmpsl_pkg::PDATA_W-1:0]        pwdata,
    output logic [tmpsl_pkg::PDATA_W-1:0]        prdata,
    output logic                                 pready
);
    import tmpsl_pkg::*;

    localparam int PIPE_STAGES = 3;

    logic [DATA_W-1:0]      kp_reg;
    logic [DATA_W-1:0]      kd_reg;
    logic [DATA_W-1:0]      ki_reg;
    gains_t                 gains;
    reg_idx_t               reg_idx;
    logic                   cfg_write;

    logic                   take;
    logic                   room;
    logic [PIPE_STAGES-1:0] valid_pipe_reg;
    logic [PIPE_STAGES-1:0] valid_pipe_next;

    logic signed [DATA_W-1:0] lane_pos [MOTOR_COUNT];
    logic signed [DATA_W-1:0] lane_sp  [MOTOR_COUNT];
    beat_t                    lane_beat;
    beat_t                    out_beat;

    // ---------------------------------------------------------------- config
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg <= KP_RESET;
            kd_reg <= KD_RESET;
            ki_reg <= KI_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_KP:  kp_reg <= pwdata[DATA_W-1:0];
                REG_KD:  kd_reg <= pwdata[DATA_W-1:0];
                REG_KI:  ki_reg <= pwdata[DATA_W-1:0];
                default: ;  // unmapped address: drop the write
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_KP:  prdata = PDATA_W'(kp_reg);
            REG_KD:  prdata = PDATA_W'(kd_reg);
            REG_KI:  prdata = PDATA_W'(ki_reg);
            default: prdata = '0;
        endcase
    end

    assign gains.kp = kp_reg;
    assign gains.kd = kd_reg;
    assign gains.ki = ki_reg;

    // ----------------------------------------------------------------- lanes
    assign in_ready = room;
    assign take     = in_valid && in_ready;

    assign lane_pos[0] = position_a;
    assign lane_pos[1] = position_b;
    assign lane_pos[2] = position_c;
    assign lane_sp[0]  = setpoint_a;
    assign lane_sp[1]  = setpoint_b;
    assign lane_sp[2]  = setpoint_c;

    for (genvar g = 0; g < MOTOR_COUNT; g++)
    begin : g_lane
        tmpsl_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .take     (take),
            .position (lane_pos[g]),
            .setpoint (lane_sp[g]),
            .gains    (gains),
            .result   (lane_beat[g])
        );
    end

    // track which lane stages hold a live tick; advance every cycle
    assign valid_pipe_next = {valid_pipe_reg[PIPE_STAGES-2:0], take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_pipe_reg <= '0;
        end
        else
        begin
            valid_pipe_reg <= valid_pipe_next;
        end
    end

    // ----------------------------------------------------------------- merge
    tmpsl_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (valid_pipe_reg[PIPE_STAGES-1]),
        .push_data (lane_beat),
        .take      (take),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_beat)
    );

    assign forward_a = out_beat[0].forward;
    assign drive_a   = out_beat[0].drive;
    assign speed_a   = out_beat[0].speed;
    assign forward_b = out_beat[1].forward;
    assign drive_b   = out_beat[1].drive;
    assign speed_b   = out_beat[1].speed;
    assign forward_c = out_beat[2].forward;
    assign drive_c   = out_beat[2].drive;
    assign speed_c   = out_beat[2].speed;

endmodule

// ----- hdl/tmpsl_lane.sv -----
// ----------------------------------------------------------------------------
// tmpsl_lane - one motor's PID pipeline
// Speed, error and error sum at accept; three gain products; their sum;
// then shift toward zero and saturate to signed 16 bits.
// ----------------------------------------------------------------------------
module tmpsl_lane (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               take,
    input  logic signed [tmpsl_pkg::DATA_W-1:0] position,
    input  logic signed [tmpsl_pkg::DATA_W-1:0] setpoint,
    input  tmpsl_pkg::gains_t                  gains,
    output tmpsl_pkg::lane_res_t               result
);
    import tmpsl_pkg::*;

    localparam logic [MAG_W-1:0] POS_LIMIT = MAG_W'(32767);
    localparam logic [MAG_W-1:0] NEG_LIMIT = MAG_W'(32768);

    logic signed [DATA_W-1:0] prev_pos_reg;
    logic signed [DATA_W-1:0] err_sum_reg;
    logic signed [DATA_W-1:0] speed_now;
    logic signed [DATA_W-1:0] err_now;
    logic signed [DATA_W-1:0] sum_now;

    logic signed [DATA_W-1:0] speed_s1_reg;
    logic signed [DATA_W-1:0] err_s1_reg;
    logic signed [DATA_W-1:0] sum_s1_reg;

    logic signed [DATA_W:0]   kp_s;
    logic signed [DATA_W:0]   kd_s;
    logic signed [DATA_W:0]   ki_s;
    logic signed [PROD_W-1:0] prod_p_next;
    logic signed [PROD_W-1:0] prod_d_next;
    logic signed [PROD_W-1:0] prod_i_next;
    logic signed [PROD_W-1:0] prod_p_reg;
    logic signed [PROD_W-1:0] prod_d_reg;
    logic signed [PROD_W-1:0] prod_i_reg;
    logic signed [DATA_W-1:0] speed_s2_reg;

    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [DATA_W-1:0] speed_s3_reg;

    logic                     neg;
    logic [ACC_W-1:0]         abs_acc;
    logic [MAG_W-1:0]         mag;

    // 16-bit wrapping speed, error and running sum
    assign speed_now = position - prev_pos_reg;
    assign err_now   = setpoint - speed_now;
    assign sum_now   = err_sum_reg + err_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pos_reg <= '0;
            err_sum_reg  <= '0;
        end
        else if (take)
        begin
            prev_pos_reg <= position;
            err_sum_reg  <= sum_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            speed_s1_reg <= speed_now;
            err_s1_reg   <= err_now;
            sum_s1_reg   <= sum_now;
        end
    end

    assign kp_s = $signed({1'b0, gains.kp});
    assign kd_s = $signed({1'b0, gains.kd});
    assign ki_s = $signed({1'b0, gains.ki});

    assign prod_p_next = kp_s * err_s1_reg;
    assign prod_d_next = kd_s * speed_s1_reg;
    assign prod_i_next = ki_s * sum_s1_reg;

    always_ff @(posedge clk)
    begin
        prod_p_reg   <= prod_p_next;
        prod_d_reg   <= prod_d_next;
        prod_i_reg   <= prod_i_next;
        speed_s2_reg <= speed_s1_reg;
    end

    assign acc_next = ACC_W'(prod_p_reg) + ACC_W'(prod_d_reg) + ACC_W'(prod_i_reg);

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        speed_s3_reg <= speed_s2_reg;
    end

    // truncate toward zero: shift the magnitude, then saturate per sign
    assign neg     = acc_reg[ACC_W-1];
    assign abs_acc = neg ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign mag     = abs_acc[ACC_W-1:GAIN_FRAC_BITS];

    always_comb
    begin
        result.speed   = speed_s3_reg;
        result.forward = !(neg && (mag != '0));
        if (result.forward)
        begin
            result.drive = (mag > POS_LIMIT) ? POS_LIMIT[DATA_W-1:0] : mag[DATA_W-1:0];
        end
        else
        begin
            result.drive = (mag > NEG_LIMIT) ? NEG_LIMIT[DATA_W-1:0] : mag[DATA_W-1:0];
        end
    end

endmodule

// ----- hdl/tmpsl_merge.sv -----
// ----------------------------------------------------------------------------
// tmpsl_merge - result queue
// Packs the lane results of one tick into a beat and queues it; grants
// input credit while room remains for every tick in flight.
// ----------------------------------------------------------------------------
module tmpsl_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tmpsl_pkg::beat_t    push_data,
    input  logic                take,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output tmpsl_pkg::beat_t    out_data
);
    import tmpsl_pkg::*;

    beat_t                queue_mem [QUEUE_DEPTH];
    logic [QUEUE_IDX_W-1:0] wr_ptr_reg;
    logic [QUEUE_IDX_W-1:0] rd_ptr_reg;
    logic [CREDIT_W-1:0]    fill_reg;
    logic [CREDIT_W-1:0]    fill_next;
    logic [CREDIT_W-1:0]    credit_reg;
    logic [CREDIT_W-1:0]    credit_next;
    logic                   pop;

    assign out_valid = (fill_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = queue_mem[rd_ptr_reg];
    // one credit per tick accepted and not yet delivered
    assign room      = (credit_reg < CREDIT_W'(QUEUE_DEPTH));

    assign fill_next   = fill_reg + CREDIT_W'(push) - CREDIT_W'(pop);
    assign credit_next = credit_reg + CREDIT_W'(take) - CREDIT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            credit_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg   <= fill_next;
            credit_reg <= credit_next;
        end
    end

endmodule

// ----- bench/speed_loop_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speed_loop_checker - drive prediction and result checking for the speed loop
// Watches the tick, result and APB channels. Keeps its own gains, previous
// counts and error sums, predicts each result beat and compares it field by
// field. Also checks APB read data against the gains it has seen written.
// ----------------------------------------------------------------------------
module speed_loop_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic signed [tmpsl_pkg::DATA_W-1:0]  position_a,
    input  logic signed [tmpsl_pkg::DATA_W-1:0]  position_b,
    input  logic signed [tmpsl_pkg::DATA_W-1:0]  position_c,
    input  logic signed [tmpsl_pkg::DATA_W-1:0]  setpoint_a,
    input  logic signed [tmpsl_pkg::DATA_W-1:0]  setpoint_b,
    input  logic signed [tmpsl_pkg::DATA_W-1:0]  setpoint_c,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic                                 forward_a,
    input  logic [tmpsl_pkg::DATA_W-1:0]         drive_a,
    input  logic signed [tmpsl_pkg::DATA_W-1:0]  speed_a,
    input  logic                                 forward_b,
    input  logic [tmpsl_pkg::DATA_W-1:0]         drive_b,
    input  logic signed [tmpsl_pkg::DATA_W-1:0]  speed_b,
    input  logic                                 forward_c,
    input  logic [tmpsl_pkg::DATA_W-1:0]         drive_c,
    input  logic signed [tmpsl_pkg::DATA_W-1:0]  speed_c,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tmpsl_pkg::PADDR_W-1:0]        paddr,
    input  logic [tmpsl_pkg::PDATA_W-1:0]        pwdata,
    input  logic [tmpsl_pkg::PDATA_W-1:0]        prdata,
    input  logic                                 pready,
    output int                                   fail_count,
    output int                                   ticks_in_flight
);
    import tmpsl_pkg::*;

    localparam int SHOWN_MISMATCHES = 10;

    logic [DATA_W-1:0] kp_gain;
    logic [DATA_W-1:0] kd_gain;
    logic [DATA_W-1:0] ki_gain;
    logic [DATA_W-1:0] prev_count [MOTOR_COUNT];
    logic [DATA_W-1:0] error_sum [MOTOR_COUNT];
    beat_t             expected_beats [$];
    int                miss_total = 0;
    string             lane_tag [MOTOR_COUNT] = '{"a", "b", "c"};

    assign fail_count = miss_total;

    function automatic void log_failure(string msg);
        miss_total++;
        if (miss_total <= SHOWN_MISMATCHES)
            $display("%0t checker: %s", $time, msg);
    endfunction

    function automatic void compare_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want)
            log_failure($sformatf("%s expected 0x%0h, got 0x%0h", what, want, got));
    endfunction

    // One lane of one tick: speed, error, wrapped sum, then the scaled drive.
    function automatic lane_res_t advance_lane(int m, logic [DATA_W-1:0] count,
                                               logic [DATA_W-1:0] target);
        logic [DATA_W-1:0] spd;
        logic [DATA_W-1:0] err;
        longint            acc;
        longint            mag;
        longint            q;
        lane_res_t         r;
        spd = count - prev_count[m];
        err = target - spd;
        error_sum[m] = error_sum[m] + err;
        acc = longint'(kp_gain) * longint'($signed(err))
            + longint'(kd_gain) * longint'($signed(spd))
            + longint'(ki_gain) * longint'($signed(error_sum[m]));
        // truncate toward zero: shift the magnitude, then restore the sign
        mag = (acc < 0) ? -acc : acc;
        mag = mag >> GAIN_FRAC_BITS;
        q = (acc < 0) ? -mag : mag;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        r.forward = (q >= 0);
        r.drive   = DATA_W'((q >= 0) ? q : -q);
        r.speed   = spd;
        prev_count[m] = count;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        beat_t want;
        beat_t got;
        if (!rst_n) begin
            kp_gain = KP_RESET;
            kd_gain = KD_RESET;
            ki_gain = KI_RESET;
            for (int m = 0; m < MOTOR_COUNT; m++) begin
                prev_count[m] = '0;
                error_sum[m]  = '0;
            end
            expected_beats.delete();
            ticks_in_flight <= 0;
        end
        else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[PADDR_W-1:2])
                        REG_KP:  kp_gain = pwdata[DATA_W-1:0];
                        REG_KD:  kd_gain = pwdata[DATA_W-1:0];
                        REG_KI:  ki_gain = pwdata[DATA_W-1:0];
                        default: ;
                    endcase
                end
                else begin
                    case (paddr[PADDR_W-1:2])
                        REG_KP:  compare_field("kp_gain read", 32'(kp_gain), prdata);
                        REG_KD:  compare_field("kd_gain read", 32'(kd_gain), prdata);
                        REG_KI:  compare_field("ki_gain read", 32'(ki_gain), prdata);
                        default: ;
                    endcase
                end
            end

            if (in_valid && in_ready) begin
                want[0] = advance_lane(0, position_a, setpoint_a);
                want[1] = advance_lane(1, position_b, setpoint_b);
                want[2] = advance_lane(2, position_c, setpoint_c);
                expected_beats.push_back(want);
            end

            if (out_valid && out_ready) begin
                got[0].forward = forward_a;
                got[0].drive   = drive_a;
                got[0].speed   = speed_a;
                got[1].forward = forward_b;
                got[1].drive   = drive_b;
                got[1].speed   = speed_b;
                got[2].forward = forward_c;
                got[2].drive   = drive_c;
                got[2].speed   = speed_c;
                if (expected_beats.size() == 0) begin
                    log_failure("result beat with no tick waiting");
                end
                else begin
                    want = expected_beats.pop_front();
                    for (int m = 0; m < MOTOR_COUNT; m++) begin
                        compare_field($sformatf("forward_%s", lane_tag[m]),
                                      32'(want[m].forward), 32'(got[m].forward));
                        compare_field($sformatf("drive_%s", lane_tag[m]),
                                      32'(want[m].drive), 32'(got[m].drive));
                        compare_field($sformatf("speed_%s", lane_tag[m]),
                                      32'(want[m].speed), 32'(got[m].speed));
                    end
                end
            end
            ticks_in_flight <= expected_beats.size();
        end
    end

endmodule

// ----- bench/three_motor_pid_speed_loop_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_motor_pid_speed_loop_top_tb - testbench of the three-motor speed loop
// Drives control ticks and APB gain writes into the block, with random
// idling on both channels, and leaves prediction and checking to the
// checker instance that sits beside the block.
// ----------------------------------------------------------------------------
module three_motor_pid_speed_loop_top_tb;
    import tmpsl_pkg::*;

    localparam int PHASES          = 10;
    localparam int TICKS_PER_PHASE = 165;
    localparam int HOLD_CYCLES     = 80;
    localparam int SETTLE_CYCLES   = 4;
    localparam int END_CYCLES      = 8;
    localparam int STALL_LIMIT     = 5000;
    localparam int IDLE_PERCENT    = 22;
    // index past the last gain register; writes there must be dropped
    localparam logic [REG_IDX_W-1:0] UNUSED_REG = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                     in_valid   = 1'b0;
    logic                     in_ready;
    logic signed [DATA_W-1:0] position_a = '0;
    logic signed [DATA_W-1:0] position_b = '0;
    logic signed [DATA_W-1:0] position_c = '0;
    logic signed [DATA_W-1:0] setpoint_a = '0;
    logic signed [DATA_W-1:0] setpoint_b = '0;
    logic signed [DATA_W-1:0] setpoint_c = '0;

    logic                     out_valid;
    logic                     out_ready  = 1'b0;
    logic                     forward_a;
    logic [DATA_W-1:0]        drive_a;
    logic signed [DATA_W-1:0] speed_a;
    logic                     forward_b;
    logic [DATA_W-1:0]        drive_b;
    logic signed [DATA_W-1:0] speed_b;
    logic                     forward_c;
    logic [DATA_W-1:0]        drive_c;
    logic signed [DATA_W-1:0] speed_c;

    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [PADDR_W-1:0]       paddr   = '0;
    logic [PDATA_W-1:0]       pwdata  = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;

    int fail_count;
    int ticks_in_flight;

    // steady: no idling on either side; hold_req: bump to ask the result
    // sink for one long hold-off
    bit                steady   = 1'b0;
    int                hold_req = 0;
    int                stall_cycles = 0;
    logic [DATA_W-1:0] last_count [MOTOR_COUNT];

    three_motor_pid_speed_loop_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .position_a (position_a),
        .position_b (position_b),
        .position_c (position_c),
        .setpoint_a (setpoint_a),
        .setpoint_b (setpoint_b),
        .setpoint_c (setpoint_c),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .forward_a  (forward_a),
        .drive_a    (drive_a),
        .speed_a    (speed_a),
        .forward_b  (forward_b),
        .drive_b    (drive_b),
        .speed_b    (speed_b),
        .forward_c  (forward_c),
        .drive_c    (drive_c),
        .speed_c    (speed_c),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    speed_loop_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .position_a      (position_a),
        .position_b      (position_b),
        .position_c      (position_c),
        .setpoint_a      (setpoint_a),
        .setpoint_b      (setpoint_b),
        .setpoint_c      (setpoint_c),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .forward_a       (forward_a),
        .drive_a         (drive_a),
        .speed_a         (speed_a),
        .forward_b       (forward_b),
        .drive_b         (drive_b),
        .speed_b         (speed_b),
        .forward_c       (forward_c),
        .drive_c         (drive_c),
        .speed_c         (speed_c),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .ticks_in_flight (ticks_in_flight)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result sink: random back-pressure, or a long hold-off on request.
    // While held off the queue fills and in_ready has to drop.
    initial
    begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
            end
            else
            begin
                out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // Watchdog: any beat on any channel restarts the count.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Encoder counts: mostly a motor turning at a plausible rate, otherwise
    // jumps anywhere in the 16-bit range or to the range ends.
    function automatic logic [DATA_W-1:0] pick_extreme();
        case ($urandom_range(3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_count(logic [DATA_W-1:0] prev);
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return prev + DATA_W'($urandom_range(600)) - 16'd300;
        else if (roll < 85)
            return DATA_W'($urandom);
        else
            return pick_extreme();
    endfunction

    function automatic logic [DATA_W-1:0] pick_target();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return DATA_W'($urandom_range(600)) - 16'd300;
        else if (roll < 85)
            return DATA_W'($urandom);
        else
            return pick_extreme();
    endfunction

    function automatic logic [DATA_W-1:0] pick_gain();
        if ($urandom_range(1) != 0)
            return DATA_W'($urandom_range(65535));
        else
            return DATA_W'($urandom_range(8192));
    endfunction

    // Offer one tick and hold it until the block takes it.
    task automatic send_tick(input logic [DATA_W-1:0] pa, input logic [DATA_W-1:0] pb,
                             input logic [DATA_W-1:0] pc, input logic [DATA_W-1:0] sa,
                             input logic [DATA_W-1:0] sb, input logic [DATA_W-1:0] sc);
        in_valid   <= 1'b1;
        position_a <= pa;
        position_b <= pb;
        position_c <= pc;
        setpoint_a <= sa;
        setpoint_b <= sb;
        setpoint_c <= sc;
        last_count[0] = pa;
        last_count[1] = pb;
        last_count[2] = pc;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid for a random number of cycles, unless running steady.
    task automatic sender_gap();
        if (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (!steady && $urandom_range(99) < IDLE_PERCENT);
        end
    endtask

    task automatic random_tick();
        sender_gap();
        send_tick(pick_count(last_count[0]), pick_count(last_count[1]),
                  pick_count(last_count[2]), pick_target(), pick_target(), pick_target());
    endtask

    // One APB transfer: setup cycle, access cycle, then idle with psel low so
    // that psel never gets two assignments in one step.
    task automatic apb_access(input bit is_write, input logic [REG_IDX_W-1:0] idx,
                              input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic readback_gains();
        apb_access(1'b0, REG_KP, '0);
        apb_access(1'b0, REG_KD, '0);
        apb_access(1'b0, REG_KI, '0);
    endtask

    // Gains change only with the block idle: drop valid, wait for every
    // outstanding result, let the pipeline settle, then write and read back.
    // The in-flight count is registered, so it lags the accepting edge; wait
    // for the next edge before trusting it.
    task automatic set_gains(input logic [DATA_W-1:0] kp, input logic [DATA_W-1:0] kd,
                             input logic [DATA_W-1:0] ki);
        in_valid <= 1'b0;
        @(posedge clk);
        while (ticks_in_flight != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        apb_access(1'b1, REG_KP, kp);
        apb_access(1'b1, REG_KD, kd);
        apb_access(1'b1, REG_KI, ki);
        readback_gains();
    endtask

    initial
    begin
        for (int m = 0; m < MOTOR_COUNT; m++)
            last_count[m] = '0;

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gains must read back before anything is written
        readback_gains();

        // First tick after reset: speed equals the count itself.
        send_tick(16'h7FFF, 16'h8000, 16'h0001, 16'h0000, 16'h7FFF, 16'h8000);
        // Count wrap in both directions, setpoint at both ends.
        send_tick(16'h8000, 16'h7FFF, 16'h0001, 16'h8000, 16'h8000, 16'h7FFF);
        // Large errors in a row: the error sums wrap.
        send_tick(16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_tick(16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_tick(16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001);

        // Full-scale gains: drive saturates both ways.
        set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_tick(16'h7FFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000);
        send_tick(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000);
        send_tick(16'h0001, 16'h0002, 16'h0003, 16'h0000, 16'h0000, 16'h0000);

        // Smallest gain: plus or minus one LSB truncates to zero drive.
        set_gains(16'h0001, 16'h0000, 16'h0000);
        send_tick(16'h0001, 16'h0002, 16'h0003, 16'hFFFF, 16'h0001, 16'h0000);

        // Zero gains.
        set_gains(16'h0000, 16'h0000, 16'h0000);
        send_tick(16'h0064, 16'hFF9C, 16'h7FFF, 16'h0005, 16'hFFFB, 16'h7FFF);

        // Unity kp: an error of -32768 gives exactly -32768, no saturation.
        // Also write past the last register; the gains must not move.
        set_gains(16'h1000, 16'h0000, 16'h0000);
        apb_access(1'b1, UNUSED_REG, 16'hFFFF);
        readback_gains();
        send_tick(16'h0064, 16'hFF9C, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_tick(16'hFF9C, 16'h0064, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

        // Random part, one gain setting per phase.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       set_gains(KP_RESET, KD_RESET, KI_RESET);
                1:       set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
                3:       set_gains(16'h0000, 16'hFFFF, 16'h0000);
                4:       set_gains(16'h0000, 16'h0000, 16'hFFFF);
                default: set_gains(pick_gain(), pick_gain(), pick_gain());
            endcase
            // one phase runs with no idling at all
            steady = (ph == 5);
            for (int n = 0; n < TICKS_PER_PHASE; n++)
            begin
                // keep offering ticks while the sink holds off
                if (ph == 6 && n == 40)
                    hold_req++;
                random_tick();
            end
        end

        // Drain: wait for every result, then a few more cycles for strays.
        in_valid <= 1'b0;
        @(posedge clk);
        while (ticks_in_flight != 0)
            @(posedge clk);
        repeat (END_CYCLES)
            @(posedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
